[src/rtat_pkg.sv]
package rtat_pkg;

    // table geometry
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int DATA_W            = 64;
    localparam int SLOT_W            = 4;
    localparam int STATUS_W          = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 328;
    localparam int M_TDATA_W = 72;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam logic REG_BACKING_SIZE = 1'b0;

    // item kinds carried in s_tuser
    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_LOAD      = 1'b1;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PAST_BACKING = 2'd3;

    // one table entry
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] boff;
    } entry_t;

    // one translate answer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   file_offset;
        logic [SLOT_W-1:0]   range_index;
    } result_t;

endpackage

[src/rtat_table.sv]
module rtat_table
    import rtat_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W   = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    output logic             rd_valid
);

    entry_t                 mem [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;

    // entry storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits, cleared at reset so unwritten entries never qualify
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[src/rtat_ctrl.sv]
module rtat_ctrl
    import rtat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    // incoming item
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_action,
    input  logic [SLOT_W-1:0] in_index,
    input  entry_t            in_entry,
    input  logic [DATA_W-1:0] in_address,
    input  logic [DATA_W-1:0] in_length,
    input  logic [DATA_W-1:0] backing_size,
    // table access
    output logic              tbl_wr_en,
    output logic [IDX_W-1:0]  tbl_wr_addr,
    output entry_t            tbl_wr_data,
    output logic              tbl_rd_en,
    output logic [IDX_W-1:0]  tbl_rd_addr,
    input  entry_t            tbl_rd_data,
    input  logic              tbl_rd_valid,
    // result hand-off
    input  logic              out_free,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_CHK1  = 3'd3;
    localparam logic [2:0] S_CHK2  = 3'd4;
    localparam logic [2:0] S_CHK3  = 3'd5;
    localparam logic [2:0] S_CHK4  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    logic [DATA_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] len_reg, len_next;
    logic [DATA_W-1:0] off_reg, off_next;
    logic [DATA_W-1:0] bmb_reg, bmb_next;
    logic              boff_ok_reg, boff_ok_next;
    logic [DATA_W-1:0] foff_reg, foff_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              take;
    logic [DATA_W-1:0] off_c;
    logic              bad_range;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // loads go straight into the table; reads only happen later in the sweep
    assign tbl_wr_en   = accept && (in_action == ACT_LOAD) && (32'(in_index) < TABLE_ENTRIES);
    assign tbl_wr_addr = IDX_W'(in_index);
    assign tbl_wr_data = in_entry;

    assign tbl_rd_en   = (state_reg == S_SWEEP);
    assign tbl_rd_addr = cnt_reg;

    // running best candidate, later index wins a tie on base
    assign take = cmp_pend_reg && tbl_rd_valid && (tbl_rd_data.base <= addr_reg) &&
                  (!found_reg || (tbl_rd_data.base >= best_reg.base));

    // containment check on the chosen entry
    assign off_c     = addr_reg - best_reg.base;
    assign bad_range = (best_reg.size == '0) || (best_reg.size > ~best_reg.base) ||
                       (off_c >= best_reg.size);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_pend_next = (state_reg == S_SWEEP);
        cmp_idx_next  = cnt_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        off_next      = off_reg;
        bmb_next      = bmb_reg;
        boff_ok_next  = boff_ok_reg;
        foff_next     = foff_reg;
        res_next      = res_reg;
        res_valid     = 1'b0;

        if (take)
        begin
            found_next    = 1'b1;
            best_next     = tbl_rd_data;
            best_idx_next = cmp_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_action == ACT_TRANSLATE))
                begin
                    addr_next  = in_address;
                    len_next   = in_length;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                off_next = off_c;
                res_next.file_offset = '0;
                res_next.range_index = SLOT_W'(best_idx_reg);
                if (!found_reg)
                begin
                    res_next.status      = ST_NO_RANGE;
                    res_next.range_index = '0;
                    state_next           = S_DONE;
                end
                else if (bad_range)
                begin
                    res_next.status = ST_NO_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                boff_ok_next = (best_reg.boff <= backing_size);
                bmb_next     = backing_size - best_reg.boff;
                if (len_reg > (best_reg.size - off_reg))
                begin
                    res_next.status = ST_PAST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CHK3;
                end
            end
            S_CHK3:
            begin
                foff_next = best_reg.boff + off_reg;
                if (!boff_ok_reg || (off_reg > bmb_reg))
                begin
                    res_next.status = ST_PAST_BACKING;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CHK4;
                end
            end
            S_CHK4:
            begin
                if (len_reg > (backing_size - foff_reg))
                begin
                    res_next.status = ST_PAST_BACKING;
                end
                else
                begin
                    res_next.status      = ST_OK;
                    res_next.file_offset = foff_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_pend_reg <= cmp_pend_next;
            found_reg    <= found_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        off_reg      <= off_next;
        bmb_reg      <= bmb_next;
        boff_ok_reg  <= boff_ok_next;
        foff_reg     <= foff_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule

[src/range_table_address_translator.sv]
// Range table address translator.
// Input stream s_*: one beat is either a load (s_tuser = 1) that writes one
// table entry, or a translate (s_tuser = 0) that looks up an address and a
// length. Loads give no output beat; each translate gives exactly one.
// Output stream m_*: status in m_tuser, file offset and entry index in m_tdata.
// Config: APB register 0 at byte address 0 is the 64-bit backing size.
// Loads go straight to the table and s_tready stays high. A translate reads
// every table entry once through the single read port of the entry memory,
// then runs up to four checks and stops at the first failing check. The next
// input beat can be taken at the same edge at which the output beat can first
// leave.
// The output beat sits in a register; a new item is accepted while it waits,
// and a finished translate is held inside, with s_tready low, until the
// register frees up.
// Reset clears all valid bits, the backing size and both streams; no
// clearing pass runs, the table is usable right after reset.
module range_table_address_translator
    import rtat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index[3:0], entry_base, entry_size, entry_file_offset, address,
    // length (64 bits each, from bit 4 up), zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                  s_tuser,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // file_offset[63:0], range_index[67:64], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [STATUS_W-1:0]   m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [DATA_W-1:0] backing_size_reg;
    logic              m_tvalid_reg;
    result_t           out_reg;

    logic [SLOT_W-1:0] in_index;
    entry_t            in_entry;
    logic [DATA_W-1:0] in_address;
    logic [DATA_W-1:0] in_length;

    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    entry_t            tbl_rd_data;
    logic              tbl_rd_valid;

    logic              out_free;
    logic              res_valid;
    result_t           res;
    logic              cfg_write;

    // unpack the input beat
    assign in_index      = s_tdata[3:0];
    assign in_entry.base = s_tdata[67:4];
    assign in_entry.size = s_tdata[131:68];
    assign in_entry.boff = s_tdata[195:132];
    assign in_address    = s_tdata[259:196];
    assign in_length     = s_tdata[323:260];

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == REG_BACKING_SIZE) ? backing_size_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backing_size_reg <= '0;
        end
        else if (cfg_write && (paddr[3] == REG_BACKING_SIZE))
        begin
            backing_size_reg <= pwdata;
        end
    end

    rtat_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_data  (tbl_wr_data),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_data  (tbl_rd_data),
        .rd_valid (tbl_rd_valid)
    );

    rtat_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (s_tuser),
        .in_index     (in_index),
        .in_entry     (in_entry),
        .in_address   (in_address),
        .in_length    (in_length),
        .backing_size (backing_size_reg),
        .tbl_wr_en    (tbl_wr_en),
        .tbl_wr_addr  (tbl_wr_addr),
        .tbl_wr_data  (tbl_wr_data),
        .tbl_rd_en    (tbl_rd_en),
        .tbl_rd_addr  (tbl_rd_addr),
        .tbl_rd_data  (tbl_rd_data),
        .tbl_rd_valid (tbl_rd_valid),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - SLOT_W){1'b0}},
                       out_reg.range_index, out_reg.file_offset};

endmodule

[src/rtat_checker.sv]
module rtat_checker
    import rtat_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // a stalled output beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output beat changed while stalled");

    // a translate occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_TRANSLATE)) |=> !s_tready)
        else $error("input taken during a translate");

    // a load leaves s_tready high in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_LOAD)) |=> s_tready)
        else $error("load blocked the input");

    // failed translations carry a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("nonzero offset on failed translation");

    // pad bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:DATA_W+SLOT_W] == '0))
        else $error("output pad bits set");

endmodule

bind range_table_address_translator rtat_checker u_rtat_checker (.*);
